### rtl/core/uart8_pkg.sv
// ----------------------------------------------------------------------------
// uart8_pkg
// Shared types and constants for the 8N1 half-bit UART transceiver.
// ----------------------------------------------------------------------------
package uart8_pkg;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;

  localparam logic [4:0] TX_LAST_PHASE = 5'd19;
  localparam logic [4:0] TX_STOP_PHASE = 5'd17;
  localparam logic [4:0] TX_DATA_END   = 5'd15;
  localparam logic [4:0] RX_STOP_PHASE = 5'd18;

  localparam logic [15:0] HALF_BIT_RESET = 16'd207;

  // Register index within the configuration space
  localparam logic REG_HALF_BIT = 1'b0;

  typedef enum logic [1:0] {
    ST_NONE   = 2'd0,
    ST_ACCEPT = 2'd1,
    ST_REJECT = 2'd2
  } status_t;

  // One classified tick waiting for the engine
  typedef struct packed {
    logic       offer;
    logic [7:0] byte_val;
    logic       last;
    logic       level;
  } tick_t;

  typedef struct packed {
    logic       tx_line;
    status_t    status;
    logic       tx_busy;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       frame_error;
  } result_t;

endpackage

### rtl/core/uart8_front.sv
// ----------------------------------------------------------------------------
// uart8_front
// Input side: classifies each tick and queues it for the engine.
// ----------------------------------------------------------------------------
module uart8_front import uart8_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_kind,
  input  logic [7:0] in_tx_byte,
  input  logic       in_tx_last,
  input  logic       in_rx_level,
  output logic       q_valid,
  output tick_t      q_item,
  input  logic       q_ready
);

  tick_t             mem [QDepth];
  logic [QPtrW-1:0]  wr_ptr_r;
  logic [QPtrW-1:0]  rd_ptr_r;
  logic [QCntW-1:0]  count_r;
  logic              push;
  logic              pop;
  tick_t             item;

  assign in_ready = (count_r != QCntW'(QDepth));
  assign q_valid  = (count_r != '0);
  assign q_item   = mem[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    item.offer    = in_kind;
    // plain ticks carry no byte; keep the payload quiet
    item.byte_val = in_kind ? in_tx_byte : 8'd0;
    item.last     = in_kind & in_tx_last;
    item.level    = in_rx_level;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPtrW'(1);
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + QCntW'(1);
        2'b01:   count_r <= count_r - QCntW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

### rtl/core/uart8_back.sv
// ----------------------------------------------------------------------------
// uart8_back
// Engine: transmit and receive timers, bit sequencing, result register.
// ----------------------------------------------------------------------------
module uart8_back import uart8_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] half_bit_count,
  input  logic        q_valid,
  input  tick_t       q_item,
  output logic        q_ready,
  output logic        res_valid,
  output result_t     res,
  input  logic        res_ready
);

  logic [4:0]  tx_phase_r,  tx_phase_nxt;
  logic [15:0] tx_div_r,    tx_div_nxt;
  logic [7:0]  tx_active_r, tx_active_nxt;
  logic [7:0]  tx_hold_r,   tx_hold_nxt;
  logic        tx_full_r,   tx_full_nxt;
  logic        tx_run_r,    tx_run_nxt;
  logic        tx_level_r,  tx_level_nxt;
  logic        burst_r,     burst_nxt;
  logic [4:0]  rx_phase_r,  rx_phase_nxt;
  logic [15:0] rx_div_r,    rx_div_nxt;
  logic [7:0]  rx_shift_r,  rx_shift_nxt;
  logic        rx_run_r,    rx_run_nxt;
  logic        rx_prev_r,   rx_prev_nxt;
  logic        res_valid_r;
  result_t     res_r,       res_nxt;
  logic        take;
  logic [2:0]  rx_bit_idx;

  assign q_ready   = !res_valid_r || res_ready;
  assign take      = q_valid && q_ready;
  assign res_valid = res_valid_r;
  assign res       = res_r;
  assign rx_bit_idx = rx_phase_r[3:1] - 3'd1;

  always_comb begin
    tx_phase_nxt  = tx_phase_r;
    tx_div_nxt    = tx_div_r;
    tx_active_nxt = tx_active_r;
    tx_hold_nxt   = tx_hold_r;
    tx_full_nxt   = tx_full_r;
    tx_run_nxt    = tx_run_r;
    tx_level_nxt  = tx_level_r;
    burst_nxt     = burst_r;
    rx_phase_nxt  = rx_phase_r;
    rx_div_nxt    = rx_div_r;
    rx_shift_nxt  = rx_shift_r;
    rx_run_nxt    = rx_run_r;
    res_nxt       = '0;
    res_nxt.status = ST_NONE;

    // transmit timer advances before the offer is handled
    if (tx_run_r) begin
      if (tx_div_r >= half_bit_count) begin
        tx_div_nxt = '0;
        if (tx_phase_r == TX_LAST_PHASE) begin
          tx_phase_nxt = '0;
          if (tx_full_r) begin
            tx_active_nxt = tx_hold_r;
            tx_full_nxt   = 1'b0;
            tx_level_nxt  = 1'b0;
          end else begin
            tx_run_nxt    = 1'b0;
            tx_level_nxt  = 1'b1;
          end
        end else if (tx_phase_r > TX_LAST_PHASE) begin
          tx_phase_nxt = '0;
        end else begin
          if (tx_phase_r[0] && tx_phase_r <= TX_DATA_END) begin
            tx_level_nxt = tx_active_r[tx_phase_r[3:1]];
          end else if (tx_phase_r == TX_STOP_PHASE) begin
            tx_level_nxt = 1'b1;
          end
          tx_phase_nxt = tx_phase_r + 5'd1;
        end
      end else begin
        tx_div_nxt = tx_div_r + 16'd1;
      end
    end

    if (q_item.offer) begin
      if (!tx_run_nxt) begin
        tx_active_nxt  = q_item.byte_val;
        tx_level_nxt   = 1'b0;
        tx_run_nxt     = 1'b1;
        tx_phase_nxt   = '0;
        tx_div_nxt     = '0;
        res_nxt.status = ST_ACCEPT;
      end else if (!tx_full_nxt) begin
        tx_hold_nxt    = q_item.byte_val;
        tx_full_nxt    = 1'b1;
        res_nxt.status = ST_ACCEPT;
      end else begin
        res_nxt.status = ST_REJECT;
      end
      if (res_nxt.status == ST_ACCEPT) begin
        burst_nxt = !q_item.last;
      end
    end

    if (rx_run_r) begin
      if (rx_div_r >= half_bit_count) begin
        rx_div_nxt = '0;
        if (rx_phase_r == '0) begin
          // drop a false start, else move into the data bits
          if (q_item.level) begin
            rx_run_nxt = 1'b0;
          end else begin
            rx_phase_nxt = 5'd1;
          end
        end else if (rx_phase_r == RX_STOP_PHASE) begin
          res_nxt.rx_valid    = 1'b1;
          res_nxt.rx_byte     = rx_shift_r;
          res_nxt.frame_error = !q_item.level;
          rx_run_nxt          = 1'b0;
          rx_phase_nxt        = '0;
        end else if (rx_phase_r > RX_STOP_PHASE) begin
          rx_run_nxt   = 1'b0;
          rx_phase_nxt = '0;
        end else begin
          if (!rx_phase_r[0]) begin
            rx_shift_nxt[rx_bit_idx] = rx_shift_r[rx_bit_idx] | q_item.level;
          end
          rx_phase_nxt = rx_phase_r + 5'd1;
        end
      end else begin
        rx_div_nxt = rx_div_r + 16'd1;
      end
    end else if (rx_prev_r && !q_item.level) begin
      rx_run_nxt   = 1'b1;
      rx_phase_nxt = '0;
      rx_div_nxt   = '0;
      rx_shift_nxt = '0;
    end
    rx_prev_nxt = q_item.level;

    res_nxt.tx_line = tx_level_nxt;
    res_nxt.tx_busy = tx_run_nxt || tx_full_nxt || burst_nxt;
  end

  // holding byte is read only while full, so it needs no reset
  always_ff @(posedge clk) begin
    if (take) begin
      tx_hold_r <= tx_hold_nxt;
      res_r     <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_phase_r  <= '0;
      tx_div_r    <= '0;
      tx_active_r <= '0;
      tx_full_r   <= 1'b0;
      tx_run_r    <= 1'b0;
      tx_level_r  <= 1'b1;
      burst_r     <= 1'b0;
      rx_phase_r  <= '0;
      rx_div_r    <= '0;
      rx_shift_r  <= '0;
      rx_run_r    <= 1'b0;
      rx_prev_r   <= 1'b1;
      res_valid_r <= 1'b0;
    end else begin
      if (take) begin
        tx_phase_r  <= tx_phase_nxt;
        tx_div_r    <= tx_div_nxt;
        tx_active_r <= tx_active_nxt;
        tx_full_r   <= tx_full_nxt;
        tx_run_r    <= tx_run_nxt;
        tx_level_r  <= tx_level_nxt;
        burst_r     <= burst_nxt;
        rx_phase_r  <= rx_phase_nxt;
        rx_div_r    <= rx_div_nxt;
        rx_shift_r  <= rx_shift_nxt;
        rx_run_r    <= rx_run_nxt;
        rx_prev_r   <= rx_prev_nxt;
      end
      if (take) begin
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/uart_8n1_half_bit_transceiver.sv
// ----------------------------------------------------------------------------
// uart_8n1_half_bit_transceiver
// 8N1 UART with a half-bit divider; one tick per item, one result per tick.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   kind, tx_byte, tx_last, rx_level
//   out_     output     out_valid / out_ready tx_line, accept_status, tx_busy,
//                                             rx_valid, rx_byte, frame_error
//   cfg_     APB access psel & penable        half_bit_count at address 0
//
// One tick is taken every cycle while neither side stalls. A tick passes
// through the two-entry input queue and then the result register.
// The engine updates its whole state once per tick, so it sets the rate.
// Synchronous active-low reset; all timers idle, both lines read as high.
// Either side may stall; the queue and result register absorb it.
// ----------------------------------------------------------------------------
module uart_8n1_half_bit_transceiver import uart8_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [7:0]  in_tx_byte,
  input  logic        in_tx_last,
  input  logic        in_rx_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_tx_line,
  output logic [1:0]  out_accept_status,
  output logic        out_tx_busy,
  output logic        out_rx_valid,
  output logic [7:0]  out_rx_byte,
  output logic        out_frame_error,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [15:0] half_bit_r;
  logic        q_valid;
  logic        q_ready;
  tick_t       q_item;
  result_t     res;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_HALF_BIT) ? {16'd0, half_bit_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_bit_r <= HALF_BIT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_HALF_BIT) begin
      half_bit_r <= cfg_pwdata[15:0];
    end
  end

  uart8_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_kind     (in_kind),
    .in_tx_byte  (in_tx_byte),
    .in_tx_last  (in_tx_last),
    .in_rx_level (in_rx_level),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_ready     (q_ready)
  );

  uart8_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .half_bit_count (half_bit_r),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_ready        (q_ready),
    .res_valid      (out_valid),
    .res            (res),
    .res_ready      (out_ready)
  );

  assign out_tx_line       = res.tx_line;
  assign out_accept_status = res.status;
  assign out_tx_busy       = res.tx_busy;
  assign out_rx_valid      = res.rx_valid;
  assign out_rx_byte       = res.rx_byte;
  assign out_frame_error   = res.frame_error;

`ifndef SYNTHESIS
  a_ferr_with_rx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_error |-> out_rx_valid)
    else $error("frame error without a received byte");

  a_rx_byte_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rx_valid |-> out_rx_byte == 8'd0)
    else $error("received byte shown without rx_valid");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accept_status == ST_ACCEPT |-> out_tx_busy)
    else $error("byte accepted while transmitter reports idle");

  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accept_status == ST_REJECT |-> out_tx_busy)
    else $error("byte rejected while transmitter reports idle");
`endif

endmodule

### sim/tb_uart_8n1_half_bit_transceiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uart_8n1_half_bit_transceiver
// Drives one UART tick per request: the receive line level, plus an optional
// byte offered to the transmitter. Each returned line state is checked field
// by field against a cycle-free model of the transmitter and receiver, or a
// pinned value from the short table of directed ticks that comes first. Random
// ticks follow at several half-bit counts, carrying serial frames on the receive
// line, some with a low stop bit, mixed with glitches and noise. Both handshakes
// stall at random, and the result side holds off for a long stretch once.
// ----------------------------------------------------------------------------
module tb_uart_8n1_half_bit_transceiver;
  import uart8_pkg::*;

  localparam int         QUIET_LIMIT   = 3000;
  localparam int         HOLD_OFF_LEN  = 300;
  localparam logic [2:0] HALF_BIT_ADDR = 3'(4 * REG_HALF_BIT);
  localparam int         PHASES        = 6;

  typedef struct {
    int      half;
    tick_t   stim;
    bit      pinned;
    result_t want;
  } vector_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_kind;
  logic [7:0]  in_tx_byte;
  logic        in_tx_last;
  logic        in_rx_level;
  logic        out_valid;
  logic        out_ready;
  logic        out_tx_line;
  logic [1:0]  out_accept_status;
  logic        out_tx_busy;
  logic        out_rx_valid;
  logic [7:0]  out_rx_byte;
  logic        out_frame_error;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // model of the transceiver
  logic [15:0] half_ticks     = HALF_BIT_RESET;
  logic [4:0]  tx_step_idx    = '0;
  logic [15:0] tx_count       = '0;
  logic [7:0]  tx_shift_out   = '0;
  logic [7:0]  tx_spare       = '0;
  logic        tx_spare_full  = 1'b0;
  logic        tx_on          = 1'b0;
  logic        tx_pin         = 1'b1;
  logic        burst_pending  = 1'b0;
  logic [4:0]  rx_step_idx    = '0;
  logic [15:0] rx_count       = '0;
  logic [7:0]  rx_gather      = '0;
  logic        rx_on          = 1'b0;
  logic        rx_last_pin    = 1'b1;

  result_t tick_results[$];
  vector_t directed_rows[$];
  logic    rx_wave[$];
  int      cur_half      = HALF_BIT_RESET;
  int      error_count   = 0;
  int      results_seen  = 0;
  int      quiet_cycles  = 0;
  bit      calm          = 1'b0;
  bit      hold_off_req  = 1'b0;

  int phase_half[PHASES]    = '{0, 1, 65535, 3, 2, 7};
  int phase_items[PHASES]   = '{500, 350, 150, 400, 350, 250};
  bit phase_calm[PHASES]    = '{0, 1, 0, 0, 0, 0};
  bit phase_pause[PHASES]   = '{0, 0, 0, 1, 0, 0};
  bit phase_squeeze[PHASES] = '{0, 0, 0, 0, 1, 0};

  uart_8n1_half_bit_transceiver DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_tx_byte        (in_tx_byte),
    .in_tx_last        (in_tx_last),
    .in_rx_level       (in_rx_level),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_tx_line       (out_tx_line),
    .out_accept_status (out_accept_status),
    .out_tx_busy       (out_tx_busy),
    .out_rx_valid      (out_rx_valid),
    .out_rx_byte       (out_rx_byte),
    .out_frame_error   (out_frame_error),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [16:0] divider_next(input logic [15:0] count);
    if (count >= half_ticks) return {1'b1, 16'd0};
    return {1'b0, count + 16'd1};
  endfunction

  function automatic result_t line_state(input logic line, input status_t st,
                                         input logic busy);
    result_t r;
    r = '0;
    r.tx_line = line;
    r.status  = st;
    r.tx_busy = busy;
    return r;
  endfunction

  // Advance the model by one tick and return the line state it produces
  task automatic uart_next_tick(input tick_t t, output result_t r);
    logic fired;
    r = '0;
    if (tx_on) begin
      {fired, tx_count} = divider_next(tx_count);
      if (fired) begin
        if (tx_step_idx == TX_LAST_PHASE) begin
          tx_step_idx = '0;
          if (tx_spare_full) begin
            tx_shift_out  = tx_spare;
            tx_spare_full = 1'b0;
            tx_pin        = 1'b0;
          end else begin
            tx_on  = 1'b0;
            tx_pin = 1'b1;
          end
        end else if (tx_step_idx > TX_LAST_PHASE) begin
          tx_step_idx = '0;
        end else begin
          if (tx_step_idx[0] && tx_step_idx <= TX_DATA_END)
            tx_pin = tx_shift_out[(tx_step_idx - 5'd1) >> 1];
          else if (tx_step_idx == TX_STOP_PHASE)
            tx_pin = 1'b1;
          tx_step_idx = tx_step_idx + 5'd1;
        end
      end
    end

    if (t.offer) begin
      if (!tx_on) begin
        tx_shift_out = t.byte_val;
        tx_pin       = 1'b0;
        tx_on        = 1'b1;
        tx_step_idx  = '0;
        tx_count     = '0;
        r.status     = ST_ACCEPT;
      end else if (!tx_spare_full) begin
        tx_spare      = t.byte_val;
        tx_spare_full = 1'b1;
        r.status      = ST_ACCEPT;
      end else begin
        r.status = ST_REJECT;
      end
      if (r.status == ST_ACCEPT) burst_pending = !t.last;
    end

    if (rx_on) begin
      {fired, rx_count} = divider_next(rx_count);
      if (fired) begin
        if (rx_step_idx == '0) begin
          // start bit high at its middle: drop back to idle
          if (t.level) rx_on = 1'b0;
          else rx_step_idx = 5'd1;
        end else if (rx_step_idx == RX_STOP_PHASE) begin
          r.rx_valid    = 1'b1;
          r.rx_byte     = rx_gather;
          r.frame_error = !t.level;
          rx_on         = 1'b0;
          rx_step_idx   = '0;
        end else if (rx_step_idx > RX_STOP_PHASE) begin
          rx_on       = 1'b0;
          rx_step_idx = '0;
        end else begin
          if (!rx_step_idx[0]) rx_gather[(rx_step_idx - 5'd2) >> 1] = t.level;
          rx_step_idx = rx_step_idx + 5'd1;
        end
      end
    end else if (rx_last_pin && !t.level) begin
      rx_on       = 1'b1;
      rx_step_idx = '0;
      rx_count    = '0;
      rx_gather   = '0;
    end
    rx_last_pin = t.level;

    r.tx_line = tx_pin;
    r.tx_busy = tx_on || tx_spare_full || burst_pending;
  endtask

  task automatic flag_mismatch(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    error_count++;
    $display("mismatch at result %0d, %s: got %0h, want %0h",
             results_seen, field, got, want);
  endtask

  task automatic add_row(input int half, input logic offer, input logic [7:0] data,
                         input logic last, input logic level, input bit pinned,
                         input result_t want);
    vector_t v;
    v.half          = half;
    v.stim.offer    = offer;
    v.stim.byte_val = data;
    v.stim.last     = last;
    v.stim.level    = level;
    v.pinned        = pinned;
    v.want          = want;
    directed_rows.push_back(v);
  endtask

  // Enter and leave at a falling edge
  task automatic send_tick(input tick_t t, input bit pinned, input result_t want);
    result_t predicted;
    if (!calm && $urandom_range(99) < 20) begin
      in_valid = 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_valid    = 1'b1;
    in_kind     = t.offer;
    in_tx_byte  = t.byte_val;
    in_tx_last  = t.last;
    in_rx_level = t.level;
    do @(posedge clk); while (!in_ready);
    uart_next_tick(t, predicted);
    tick_results.push_back(pinned ? want : predicted);
    @(negedge clk);
  endtask

  task automatic settle_results();
    in_valid = 1'b0;
    while (tick_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // Write the half-bit count, then read it back
  task automatic program_half_bit(input logic [15:0] value);
    logic [31:0] readback;
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr   = HALF_BIT_ADDR;
    cfg_pwdata  = {16'd0, value};
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    half_ticks = value;
    cur_half   = value;
    @(negedge clk);
    cfg_pwrite  = 1'b0;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    readback = cfg_prdata;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    if (readback[15:0] !== value) flag_mismatch("half_bit_count readback", readback, value);
  endtask

  // Queue receive-line levels: mostly clean frames at the current rate, with the bit length capped at slow rates
  task automatic plan_rx_line();
    int         span;
    int         pick;
    logic [7:0] data;
    logic       stop;
    span = (cur_half > 15) ? 32 : 2 * (cur_half + 1);
    pick = $urandom_range(99);
    repeat ($urandom_range(6)) rx_wave.push_back(1'b1);
    if (pick < 75) begin
      data = 8'($urandom);
      stop = ($urandom_range(99) >= 15);
      repeat (span) rx_wave.push_back(1'b0);
      for (int b = 0; b < 8; b++) repeat (span) rx_wave.push_back(data[b]);
      repeat (span) rx_wave.push_back(stop);
    end else if (pick < 88) begin
      // low no longer than half a bit: seen high at the start-bit middle
      repeat ($urandom_range(span / 2, 1)) rx_wave.push_back(1'b0);
      repeat (span) rx_wave.push_back(1'b1);
    end else begin
      repeat ($urandom_range(4 * span, 1)) rx_wave.push_back(1'($urandom_range(1)));
    end
    rx_wave.push_back(1'b1);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (tick_results.size() == 0) begin
        flag_mismatch("no request pending", 0, 0);
      end else begin
        want = tick_results.pop_front();
        if (out_tx_line !== want.tx_line)
          flag_mismatch("tx_line", out_tx_line, want.tx_line);
        if (out_accept_status !== want.status)
          flag_mismatch("accept_status", out_accept_status, want.status);
        if (out_tx_busy !== want.tx_busy)
          flag_mismatch("tx_busy", out_tx_busy, want.tx_busy);
        if (out_rx_valid !== want.rx_valid)
          flag_mismatch("rx_valid", out_rx_valid, want.rx_valid);
        if (out_rx_byte !== want.rx_byte)
          flag_mismatch("rx_byte", out_rx_byte, want.rx_byte);
        if (out_frame_error !== want.frame_error)
          flag_mismatch("frame_error", out_frame_error, want.frame_error);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("tb_uart_8n1_half_bit_transceiver: done, errors");
    $finish;
  end

  // Result side: random stalls, and one long hold-off on request
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready = 1'b0;
        repeat (HOLD_OFF_LEN) @(negedge clk);
        hold_off_req = 1'b0;
      end
      out_ready = calm || ($urandom_range(99) >= 20);
    end
  end

  initial begin
    tick_t t;
    int    n;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_kind     = 1'b0;
    in_tx_byte  = '0;
    in_tx_last  = 1'b0;
    in_rx_level = 1'b1;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;

    // reset rate: idle line, fill the active byte and the holding byte, then a reject
    add_row(207, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, line_state(1'b1, ST_NONE, 1'b0));
    add_row(207, 1'b1, 8'hFF, 1'b0, 1'b1, 1'b1, line_state(1'b0, ST_ACCEPT, 1'b1));
    add_row(207, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1, line_state(1'b0, ST_ACCEPT, 1'b1));
    add_row(207, 1'b1, 8'hA5, 1'b1, 1'b1, 1'b1, line_state(1'b0, ST_REJECT, 1'b1));
    // fastest rate; the transmit divider is above the new count mid-frame
    add_row(0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, '0);
    add_row(0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, '0);
    add_row(0, 1'b1, 8'h3C, 1'b1, 1'b0, 1'b0, '0);
    // start middle, all-zero data, stop sampled low: framing error
    for (int k = 0; k < 19; k++)
      add_row(0, (k == 8) || (k == 16), (k == 8) ? 8'hC3 : 8'h81, k == 16, 1'b0,
              1'b0, '0);
    add_row(0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, '0);

    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].half != cur_half) begin
        settle_results();
        program_half_bit(16'(directed_rows[i].half));
      end
      send_tick(directed_rows[i].stim, directed_rows[i].pinned, directed_rows[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      if (phase_half[p] != cur_half) begin
        settle_results();
        program_half_bit(16'(phase_half[p]));
      end
      calm = phase_calm[p];
      rx_wave.delete();
      for (n = 0; n < phase_items[p]; n++) begin
        if (n == phase_items[p] / 2) begin
          if (phase_squeeze[p]) hold_off_req = 1'b1;
          if (phase_pause[p]) settle_results();
        end
        if (rx_wave.size() == 0) plan_rx_line();
        t.level    = rx_wave.pop_front();
        t.offer    = ($urandom_range(99) < 25);
        t.byte_val = 8'($urandom);
        t.last     = 1'($urandom_range(1));
        send_tick(t, 1'b0, '0);
      end
    end
    calm = 1'b0;
    settle_results();

    if (error_count == 0) begin
      $display("tb_uart_8n1_half_bit_transceiver: done, clean");
    end else begin
      $display("tb_uart_8n1_half_bit_transceiver: done, errors");
    end
    $finish;
  end

endmodule
